// ===== rtl/bfir_pkg.sv =====
// Package for the block FIR filter: sizes, widths, opcodes and the status
// structs that pass between the filter's modules. It depends on nothing.
package bfir_pkg;

  localparam int TAPS       = 16;
  localparam int FIFO_DEPTH = 16;
  localparam int Q_SHIFT    = 15;

  localparam int OPC_W   = 2;
  localparam int IDX_W   = 4;
  localparam int SMP_W   = 16;
  localparam int COEF_W  = 16;
  localparam int ACC_W   = 32;
  localparam int DRN_W   = 5;

  // Coefficient digits fed to the serial multiplier
  localparam int DIG_W   = 4;
  localparam int NDIG    = COEF_W / DIG_W;
  localparam int DIG_CW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int PP_W    = SMP_W + DIG_W + 1;

  localparam int TAP_AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_COEF = 2'd0,
    OP_PUSH = 2'd1,
    OP_CALC = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_MAC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic full_nxt;
    logic empty_nxt;
  } fifo_stat_t;

  typedef struct packed {
    logic done;
  } mac_stat_t;

endpackage

// ===== rtl/bfir_in_if.sv =====
// Input channel of the block FIR filter: valid/ready handshake and one
// command word. Depends on bfir_pkg for the field widths.
interface bfir_in_if;
  import bfir_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [SMP_W-1:0]  sample_in;

  modport source (output valid, opcode, coef_index, coef_value, sample_in, input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, sample_in, output ready);
endinterface

// ===== rtl/bfir_out_if.sv =====
// Result channel of the block FIR filter: valid/ready handshake and one
// result word. Depends on bfir_pkg for the field widths.
interface bfir_out_if;
  import bfir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    status;
  logic signed [SMP_W-1:0] filter_out;
  logic [DRN_W-1:0]        drained_count;
  logic                    fifo_full;
  logic                    fifo_empty;

  modport source (output valid, status, filter_out, drained_count, fifo_full, fifo_empty,
                  input ready);
  modport sink   (input valid, status, filter_out, drained_count, fifo_full, fifo_empty,
                  output ready);
endinterface

// ===== rtl/bfir_fifo.sv =====
// Ring FIFO that holds pushed samples until a compute drains them.
// Depends on bfir_pkg.
module bfir_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic                              pop,
  input  logic signed [bfir_pkg::SMP_W-1:0] wdata,
  output logic signed [bfir_pkg::SMP_W-1:0] rdata,
  output bfir_pkg::fifo_stat_t              stat
);
  import bfir_pkg::*;

  logic signed [SMP_W-1:0] mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wp_r, wp_nxt;
  logic [FIFO_AW-1:0]      rp_r, rp_nxt;
  logic [FIFO_CW-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt  = (wp_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop) begin
      rp_nxt  = (rp_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign rdata          = mem[rp_r];
  assign stat.full      = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty     = (cnt_r == '0);
  assign stat.full_nxt  = (cnt_nxt == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty_nxt = (cnt_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/bfir_mac.sv =====
// Digit-serial multiply-accumulate over all taps: the coefficient shifts
// through a register one 4-bit digit per cycle. Depends on bfir_pkg.
module bfir_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [bfir_pkg::SMP_W-1:0]  win_i,
  input  logic        [bfir_pkg::COEF_W-1:0] coef_i,
  output logic        [bfir_pkg::TAP_AW-1:0] tap_idx,
  output logic        [bfir_pkg::ACC_W-1:0]  acc_o,
  output bfir_pkg::mac_stat_t                stat
);
  import bfir_pkg::*;

  logic                    busy_r;
  logic [TAP_AW-1:0]       k_r;
  logic [DIG_CW-1:0]       dcnt_r;
  logic signed [SMP_W-1:0] win_r;
  logic [COEF_W-1:0]       dig_r;
  logic [ACC_W-1:0]        acc_r;

  logic                    first_dig;
  logic                    last_dig;
  logic                    last_tap;
  logic signed [SMP_W-1:0] cur_win;
  logic [COEF_W-1:0]       cur_coef;
  logic signed [DIG_W:0]   dig_s;
  logic signed [PP_W-1:0]  pp;
  logic signed [ACC_W-1:0] pp_ext;
  logic [ACC_W-1:0]        pp_sh;

  always_comb begin
    first_dig = (dcnt_r == '0);
    last_dig  = (dcnt_r == DIG_CW'(NDIG - 1));
    last_tap  = (k_r == TAP_AW'(TAPS - 1));
    // take fresh operands on the first digit of each tap
    cur_win   = first_dig ? win_i  : win_r;
    cur_coef  = first_dig ? coef_i : dig_r;
    // the top digit carries the coefficient's sign
    if (last_dig) begin
      dig_s = {cur_coef[DIG_W-1], cur_coef[DIG_W-1:0]};
    end else begin
      dig_s = {1'b0, cur_coef[DIG_W-1:0]};
    end
    pp     = cur_win * dig_s;
    pp_ext = ACC_W'(pp);
    pp_sh  = ACC_W'(pp_ext <<< (DIG_W * int'(dcnt_r)));
  end

  assign tap_idx   = k_r;
  assign acc_o     = acc_r;
  assign stat.done = busy_r && last_dig && last_tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      dcnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= '0;
      dcnt_r <= '0;
    end else if (busy_r) begin
      if (last_dig) begin
        dcnt_r <= '0;
        if (last_tap) begin
          busy_r <= 1'b0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end else begin
        dcnt_r <= dcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
      win_r <= cur_win;
      dig_r <= cur_coef >> DIG_W;
    end
  end

endmodule

// ===== rtl/block_fir_filter_q15_unit.sv =====
// Top level of the block FIR filter: command decode, coefficient and window
// stores, result register. Depends on bfir_pkg, bfir_in_if, bfir_out_if,
// bfir_fifo and bfir_mac.
//
//   channel | port   | direction | word
//   --------+--------+-----------+-------------------------------------------
//   command | in_if  | sink      | opcode, coef_index, coef_value, sample_in
//   result  | out_if | source    | status, filter_out, drained_count, flags
//
// Coefficient write, sample push and the unused opcode finish in the cycle
// they are accepted. A compute drains the FIFO one sample per cycle, then
// runs the digit-serial multiplier over every tap, which eats the
// coefficient 4 bits at a time. Reset clears the coefficient and window
// stores and the FIFO pointers. A result held by a stalled sink blocks only
// the next command.
module block_fir_filter_q15_unit (
  input  logic clk,
  input  logic rst_n,
  bfir_in_if.sink    in_if,
  bfir_out_if.source out_if
);
  import bfir_pkg::*;

  state_t                  state_r, state_nxt;
  logic [COEF_W-1:0]       coef_mem [TAPS];
  logic signed [SMP_W-1:0] win_mem  [TAPS];
  logic [FIFO_CW-1:0]      drained_r;

  // result register
  logic                    out_valid_r;
  logic                    status_r, status_nxt;
  logic signed [SMP_W-1:0] result_r, result_nxt;
  logic [DRN_W-1:0]        drained_out_r, drained_out_nxt;
  logic                    full_r, full_nxt;
  logic                    empty_r, empty_nxt;

  logic                    accept;
  opcode_t                 op;
  logic                    out_free;
  logic                    out_load;
  logic                    push;
  logic                    pop;
  logic                    mac_start;
  logic                    coef_wr;
  logic                    drain_start;
  logic signed [SMP_W-1:0] fifo_rdata;
  fifo_stat_t              fifo_stat;
  logic [TAP_AW-1:0]       tap_idx;
  logic [ACC_W-1:0]        acc;
  mac_stat_t               mac_stat;

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;
  assign op          = opcode_t'(in_if.opcode);

  bfir_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .wdata (in_if.sample_in),
    .rdata (fifo_rdata),
    .stat  (fifo_stat)
  );

  bfir_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .win_i   (win_mem[tap_idx]),
    .coef_i  (coef_mem[tap_idx]),
    .tap_idx (tap_idx),
    .acc_o   (acc),
    .stat    (mac_stat)
  );

  // Sequence one command: decode in idle, drain, multiply-accumulate, then
  // hand the filter result to the result register.
  always_comb begin
    state_nxt       = state_r;
    out_load        = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    mac_start       = 1'b0;
    coef_wr         = 1'b0;
    drain_start     = 1'b0;
    status_nxt      = 1'b0;
    result_nxt      = '0;
    drained_out_nxt = '0;
    full_nxt        = fifo_stat.full_nxt;
    empty_nxt       = fifo_stat.empty_nxt;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_COEF: begin
              coef_wr  = (32'(in_if.coef_index) < TAPS);
              out_load = 1'b1;
            end
            OP_PUSH: begin
              push       = !fifo_stat.full;
              status_nxt = fifo_stat.full;
              out_load   = 1'b1;
            end
            OP_CALC: begin
              drain_start = 1'b1;
              if (fifo_stat.empty) begin
                mac_start = 1'b1;
                state_nxt = ST_MAC;
              end else begin
                state_nxt = ST_DRAIN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // move one sample a cycle, oldest first
        pop = 1'b1;
        if (fifo_stat.empty_nxt) begin
          mac_start = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        result_nxt      = acc[Q_SHIFT+SMP_W-1:Q_SHIFT];
        drained_out_nxt = DRN_W'(drained_r);
        full_nxt        = fifo_stat.full;
        empty_nxt       = fifo_stat.empty;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Count drained samples; those past the last tap are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drained_r <= '0;
    end else if (drain_start) begin
      drained_r <= '0;
    end else if (pop) begin
      drained_r <= drained_r + 1'b1;
    end
  end

  // Coefficient i lands at position TAPS-1-i; window fills from position 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        coef_mem[i] <= '0;
        win_mem[i]  <= '0;
      end
    end else begin
      if (coef_wr) begin
        coef_mem[TAP_AW'(TAPS - 1 - int'(in_if.coef_index))] <= in_if.coef_value;
      end
      if (pop && (32'(drained_r) < TAPS)) begin
        win_mem[TAP_AW'(drained_r)] <= fifo_rdata;
      end
    end
  end

  // Result register: hold the word until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r      <= status_nxt;
      result_r      <= result_nxt;
      drained_out_r <= drained_out_nxt;
      full_r        <= full_nxt;
      empty_r       <= empty_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = status_r;
  assign out_if.filter_out    = result_r;
  assign out_if.drained_count = drained_out_r;
  assign out_if.fifo_full     = full_r;
  assign out_if.fifo_empty    = empty_r;

endmodule

// ===== tb/block_fir_filter_q15_unit_tb.sv =====
// Self-checking testbench for block_fir_filter_q15_unit: coefficient writes,
// sample pushes and FIFO drains with a Q15 multiply-accumulate, checked word by
// word. Depends on bfir_pkg, bfir_in_if, bfir_out_if and the filter RTL.
module block_fir_filter_q15_unit_tb;
  import bfir_pkg::*;

  // One command word as the sender drives it
  typedef struct packed {
    opcode_t                  op;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [SMP_W-1:0]  smp;
  } cmd_word_t;

  // One result word as the sink sees it
  typedef struct packed {
    logic                    status;
    logic signed [SMP_W-1:0] filt;
    logic [DRN_W-1:0]        drained;
    logic                    full;
    logic                    empty;
  } result_word_t;

  logic clk;
  logic rst_n;

  bfir_in_if  in_if ();
  bfir_out_if out_if ();

  block_fir_filter_q15_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Shadow copy of the filter state: coefficient store (already reversed),
  // tap window and the sample ring with its pointers.
  logic signed [COEF_W-1:0] coef_mem [TAPS];
  logic signed [SMP_W-1:0]  win_mem  [TAPS];
  logic signed [SMP_W-1:0]  smp_ring [FIFO_DEPTH];
  int ring_wr;
  int ring_rd;
  int ring_level;

  // Results still owed by the block, oldest first
  result_word_t pending_results [$];
  result_word_t want_word;

  int mismatch_count;
  int checked_count;
  int sent_items;
  int cnt_coef, cnt_push, cnt_drop, cnt_calc, cnt_none, max_drain;

  // Random idling: off during the directed part and the back-to-back stretch
  bit idle_on;
  int sink_hold;

  // Clock: period 12
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout: results still outstanding = %0d", pending_results.size());
    $display("block_fir_filter_q15_unit test failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample or coefficient value leaning on the extremes
  function automatic logic [15:0] pick_q15();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    return 16'($urandom);
  endfunction

  function automatic cmd_word_t make_word(input opcode_t op, input int idx,
                                          input logic [15:0] coef,
                                          input logic [15:0] smp);
    cmd_word_t w;
    w.op   = op;
    w.idx  = IDX_W'(idx);
    w.coef = coef;
    w.smp  = smp;
    return w;
  endfunction

  // Advance the shadow state by one command and return the word the block owes
  function automatic result_word_t predict_filter_word(input cmd_word_t w);
    result_word_t r;
    logic [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] prod;
    int n;
    r   = '0;
    acc = '0;
    n   = 0;
    case (w.op)
      OP_COEF: begin
        cnt_coef++;
        // Reversed placement: coefficient i lands at TAPS-1-i
        if (int'(w.idx) < TAPS) coef_mem[TAPS - 1 - int'(w.idx)] = w.coef;
      end
      OP_PUSH: begin
        cnt_push++;
        if (ring_level >= FIFO_DEPTH) begin
          // Full ring: drop the sample and flag it
          r.status = 1'b1;
          cnt_drop++;
        end else begin
          smp_ring[ring_wr] = w.smp;
          ring_wr = (ring_wr + 1) % FIFO_DEPTH;
          ring_level++;
        end
      end
      OP_CALC: begin
        cnt_calc++;
        // Drain oldest first; samples past the last tap are discarded but counted
        while (ring_level > 0) begin
          if (n < TAPS) win_mem[n] = smp_ring[ring_rd];
          ring_rd = (ring_rd + 1) % FIFO_DEPTH;
          ring_level--;
          n++;
        end
        for (int k = 0; k < TAPS; k++) begin
          prod = win_mem[k] * coef_mem[k];
          acc  = acc + prod;
        end
        r.filt    = acc[Q_SHIFT +: SMP_W];
        r.drained = DRN_W'(n);
        if (n > max_drain) max_drain = n;
      end
      default: cnt_none++;
    endcase
    r.full  = (ring_level >= FIFO_DEPTH);
    r.empty = (ring_level == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d want %0d", checked_count, what, got, want);
    mismatch_count++;
  endtask

  // Drive one command word at the falling edge and hold it until accepted.
  // Valid stays high into the next call so back-to-back words never glitch.
  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.opcode     <= w.op;
    in_if.coef_index <= w.idx;
    in_if.coef_value <= w.coef;
    in_if.sample_in  <= w.smp;
    in_if.valid      <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_filter_word(w));
    if (w.op != OP_NONE) sent_items++;
  endtask

  // Sink side: ready mostly high, with random holds of random length
  initial begin
    out_if.ready = 1'b0;
    sink_hold    = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_hold = pick_gap();
      end
    end
  end

  // Check every accepted result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, filter_out", int'(out_if.filter_out), 0);
      end else begin
        want_word = pending_results.pop_front();
        if (out_if.status !== want_word.status)
          report_mismatch("status", int'(out_if.status), int'(want_word.status));
        if (out_if.filter_out !== want_word.filt)
          report_mismatch("filter_out", int'(out_if.filter_out), int'(want_word.filt));
        if (out_if.drained_count !== want_word.drained)
          report_mismatch("drained_count", int'(out_if.drained_count),
                          int'(want_word.drained));
        if (out_if.fifo_full !== want_word.full)
          report_mismatch("fifo_full", int'(out_if.fifo_full), int'(want_word.full));
        if (out_if.fifo_empty !== want_word.empty)
          report_mismatch("fifo_empty", int'(out_if.fifo_empty), int'(want_word.empty));
      end
      checked_count++;
    end
  end

  // Coefficient extremes, compute over an empty FIFO and the unused opcode
  task automatic test_coef_and_empty();
    // Three full-scale negative taps at window positions 0..2 set up the wrap later
    send_word(make_word(OP_COEF, 15, 16'h8000, 16'($urandom)));
    send_word(make_word(OP_COEF, 14, 16'h8000, 16'($urandom)));
    send_word(make_word(OP_COEF, 13, 16'h8000, 16'($urandom)));
    send_word(make_word(OP_COEF, 0, 16'h7fff, 16'($urandom)));
    // Nothing to drain: compute over the stale window
    send_word(make_word(OP_CALC, $urandom_range(0, 15), 16'($urandom), 16'($urandom)));
    send_word(make_word(OP_NONE, $urandom_range(0, 15), 16'($urandom), 16'($urandom)));
  endtask

  // Fill the FIFO, push once more into the full ring, then drain all of it.
  // Three products of 2^30 plus a positive one wrap the accumulator.
  task automatic test_fill_drop_wrap();
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (i < 3) send_word(make_word(OP_PUSH, i, 16'($urandom), 16'h8000));
      else if (i == FIFO_DEPTH - 1) send_word(make_word(OP_PUSH, i, 16'($urandom), 16'h7fff));
      else send_word(make_word(OP_PUSH, i, 16'($urandom), pick_q15()));
    end
    send_word(make_word(OP_PUSH, 5, 16'($urandom), 16'h1234));
    send_word(make_word(OP_CALC, 0, 16'($urandom), 16'($urandom)));
  endtask

  // Mostly well-formed bursts: a few coefficient writes, a run of pushes,
  // a compute. The rest is single random words of any opcode.
  task automatic run_bursts(input int target);
    int start;
    int np;
    int r;
    start = sent_items;
    while (sent_items - start < target) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 2))
          send_word(make_word(OP_COEF, $urandom_range(0, 15), pick_q15(), 16'($urandom)));
        r = $urandom_range(0, 9);
        if (r < 6) np = $urandom_range(1, 8);
        else if (r < 8) np = $urandom_range(9, FIFO_DEPTH);
        else np = $urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 4);
        repeat (np)
          send_word(make_word(OP_PUSH, $urandom_range(0, 15), 16'($urandom), pick_q15()));
        send_word(make_word(OP_CALC, $urandom_range(0, 15), 16'($urandom), 16'($urandom)));
      end else begin
        send_word(make_word(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                            16'($urandom), 16'($urandom)));
      end
    end
  endtask

  // No idling on either side: words arrive and leave back to back
  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_bursts(150);
  endtask

  // Random gaps on both sides over the bulk of the traffic
  task automatic test_random_traffic();
    idle_on = 1'b1;
    run_bursts(850);
  endtask

  initial begin
    int waited;
    rst_n            = 1'b0;
    idle_on          = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_NONE;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.sample_in  = '0;
    // Shadow state after reset
    for (int k = 0; k < TAPS; k++) begin
      coef_mem[k] = '0;
      win_mem[k]  = '0;
    end
    for (int k = 0; k < FIFO_DEPTH; k++) smp_ring[k] = '0;
    ring_wr = 0;
    ring_rd = 0;
    ring_level = 0;
    mismatch_count = 0;
    checked_count = 0;
    sent_items = 0;
    cnt_coef = 0;
    cnt_push = 0;
    cnt_drop = 0;
    cnt_calc = 0;
    cnt_none = 0;
    max_drain = 0;

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_coef_and_empty();
    test_fill_drop_wrap();
    test_back_to_back();
    test_random_traffic();

    @(negedge clk);
    in_if.valid <= 1'b0;

    // Drain: wait for every owed word, then run on before the summary
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("expected results never delivered, count", 0, pending_results.size());
    repeat (100) @(posedge clk);

    $display("covered %0d coefficient writes, %0d pushes (%0d dropped), %0d computes",
             cnt_coef, cnt_push, cnt_drop, cnt_calc);
    $display("deepest drain %0d samples, %0d unused opcodes, %0d result words checked",
             max_drain, cnt_none, checked_count);
    if (mismatch_count == 0) begin
      $display("block_fir_filter_q15_unit test passed");
    end else begin
      $display("block_fir_filter_q15_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bfir_pkg.sv
rtl/bfir_in_if.sv
rtl/bfir_out_if.sv
rtl/bfir_fifo.sv
rtl/bfir_mac.sv
rtl/block_fir_filter_q15_unit.sv
tb/block_fir_filter_q15_unit_tb.sv
